// ----- hw/rtl/fird_pkg.sv -----
package fird_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int COEF_IDX_W = 6;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int OUT_W      = 16;
    localparam int FRAC_BITS  = 17;

    // configuration registers
    localparam int TAPS_W   = 7;
    localparam int DEC_W    = 7;
    localparam int CLEN_W   = 13;
    localparam int PHASE_W  = 6;
    localparam int CPOS_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEN = 2'd2;

    localparam logic [TAPS_W-1:0] TAPS_RST = 7'd64;
    localparam logic [DEC_W-1:0]  DEC_RST  = 7'd1;
    localparam logic [CLEN_W-1:0] CLEN_RST = 13'd1024;
    localparam logic [DEC_W-1:0]  DEC_MAX  = 7'd64;
    localparam logic [CLEN_W-1:0] CLEN_MAX = 13'd4096;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam int MAX_TAPS_DEF = 64;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;    // history moves one cell up
        logic coef_we;  // load this cell's coefficient
        logic tap_en;   // cell takes part in the sum
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/fird_tap_cell.sv -----
module fird_tap_cell #(
    parameter int ACC_W = fird_pkg::PROD_W + 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fird_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [fird_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [fird_pkg::COEF_W-1:0]   i_coef,
    input  logic signed [ACC_W-1:0]              i_psum,
    input  logic                                 i_psum_vld,
    output logic signed [fird_pkg::SAMPLE_W-1:0] o_sample,
    output logic signed [ACC_W-1:0]              o_psum,
    output logic                                 o_psum_vld
);

    logic signed [fird_pkg::SAMPLE_W-1:0] r_hist;
    logic signed [fird_pkg::COEF_W-1:0]   r_coef;
    logic signed [fird_pkg::PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]              r_psum;
    logic                                 r_psum_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_hist <= i_sample;
            end
            if (i_ctrl.coef_we) begin
                r_coef <= i_coef;
            end
        end
    end

    // product, then partial sum handed to the next cell
    always_ff @(posedge i_clk) begin
        r_prod <= fird_pkg::PROD_W'(r_coef) * fird_pkg::PROD_W'(r_hist);
        r_psum <= i_psum + (i_ctrl.tap_en ? ACC_W'(r_prod) : ACC_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum_vld <= 1'b0;
        end else begin
            r_psum_vld <= i_psum_vld;
        end
    end

    assign o_sample   = r_hist;
    assign o_psum     = r_psum;
    assign o_psum_vld = r_psum_vld;

endmodule

// ----- hw/rtl/fir_decimator_core.sv -----
// channel    | dir | handshake              | payload
// s (input)  | in  | i_s_tvalid/o_s_tready  | tdata: sample, coef_index, coef_value; tuser: kind
// m (result) | out | o_m_tvalid/i_m_tready  | tdata: filtered; tlast: last_in_chunk
// cfg        | in  | i_cfg_we               | i_cfg_index, i_cfg_data
//
// coefficient writes and samples off the decimation phase start no sum and leave the input ready for the next item
// a sample on phase zero holds the next item off until its partial sum has run
// down the row of MAX_TAPS tap cells
// the result shows on o_m_tvalid after its start token passes r_go1 and r_go2 and its sum the cells and output register
// synchronous active-low reset clears history, coefficients, counters and valid flags and restores config defaults
// a waiting result holds back only a sample that would produce the next result
module fir_decimator_core #(
    parameter int MAX_TAPS = fird_pkg::MAX_TAPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [39:0]                        i_s_tdata,  // sample[15:0], coef_index[21:16], coef_value[39:22]
    input  logic                               i_s_tuser,  // kind
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fird_pkg::OUT_W-1:0]         o_m_tdata,  // filtered[15:0]
    output logic                               o_m_tlast,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [fird_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fird_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ACC_W = fird_pkg::PROD_W + $clog2(MAX_TAPS) + 1;

    // unpack the input transaction
    logic signed [fird_pkg::SAMPLE_W-1:0] w_sample;
    logic [fird_pkg::COEF_IDX_W-1:0]      w_coef_idx;
    logic signed [fird_pkg::COEF_W-1:0]   w_coef_val;

    assign w_sample   = i_s_tdata[15:0];
    assign w_coef_idx = i_s_tdata[21:16];
    assign w_coef_val = i_s_tdata[39:22];

    // configuration registers
    logic [fird_pkg::TAPS_W-1:0] r_taps;
    logic [fird_pkg::DEC_W-1:0]  r_dec;
    logic [fird_pkg::CLEN_W-1:0] r_clen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= fird_pkg::TAPS_RST;
            r_dec  <= fird_pkg::DEC_RST;
            r_clen <= fird_pkg::CLEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fird_pkg::REG_TAPS: r_taps <= i_cfg_data[fird_pkg::TAPS_W-1:0];
                fird_pkg::REG_DEC:  r_dec  <= i_cfg_data[fird_pkg::DEC_W-1:0];
                fird_pkg::REG_CLEN: r_clen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencing state
    logic [fird_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [fird_pkg::CPOS_W-1:0]  r_cpos, n_cpos;
    logic                         r_busy;       // sum running down the cells
    logic                         r_go1, r_go2; // start token, aligned to the products
    logic                         r_last_pend;  // chunk flag of the sum in flight

    logic r_out_vld;
    logic signed [fird_pkg::OUT_W-1:0] r_out_data;
    logic r_out_last;

    logic w_accept, w_is_sample, w_is_coef, w_needs_out, w_chunk_wrap, w_last_vld;
    logic [fird_pkg::DEC_W-1:0]  w_dec_eff;
    logic [fird_pkg::CLEN_W-1:0] w_clen_eff;

    assign w_is_sample = (i_s_tuser == fird_pkg::KIND_SAMPLE);
    assign w_is_coef   = (i_s_tuser == fird_pkg::KIND_COEF);
    assign w_needs_out = w_is_sample && (r_phase == '0);

    // a sample that will produce a result needs the output register free
    assign o_s_tready = !r_busy && (!w_needs_out || !r_out_vld || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // register values outside the usable range act as the nearest limit
    always_comb begin
        if (r_dec == '0) begin
            w_dec_eff = fird_pkg::DEC_W'(1);
        end else if (r_dec > fird_pkg::DEC_MAX) begin
            w_dec_eff = fird_pkg::DEC_MAX;
        end else begin
            w_dec_eff = r_dec;
        end
        if (r_clen == '0) begin
            w_clen_eff = fird_pkg::CLEN_W'(1);
        end else if (r_clen > fird_pkg::CLEN_MAX) begin
            w_clen_eff = fird_pkg::CLEN_MAX;
        end else begin
            w_clen_eff = r_clen;
        end
    end

    assign w_chunk_wrap = ({1'b0, r_cpos} + fird_pkg::CLEN_W'(1)) >= w_clen_eff;

    always_comb begin
        // phase wraps also when a smaller decimation was written mid-stream
        if (({1'b0, r_phase} + fird_pkg::DEC_W'(1)) >= w_dec_eff) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + fird_pkg::PHASE_W'(1);
        end
        if (w_chunk_wrap) begin
            n_cpos = '0;
        end else begin
            n_cpos = r_cpos + fird_pkg::CPOS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_cpos      <= '0;
            r_busy      <= 1'b0;
            r_go1       <= 1'b0;
            r_go2       <= 1'b0;
            r_last_pend <= 1'b0;
        end else begin
            r_go1 <= w_accept && w_needs_out;
            r_go2 <= r_go1;
            if (w_accept && w_is_sample) begin
                r_phase <= n_phase;
            end
            if (w_accept && w_needs_out) begin
                r_busy      <= 1'b1;
                r_cpos      <= n_cpos;
                r_last_pend <= w_chunk_wrap;
            end else if (w_last_vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    // row of tap cells: history shifts up, partial sum runs down the row
    fird_pkg::t_cell_ctrl                 w_ctrl   [MAX_TAPS];
    logic signed [fird_pkg::SAMPLE_W-1:0] w_hist   [MAX_TAPS];
    logic signed [ACC_W-1:0]              w_psum   [MAX_TAPS];
    logic                                 w_vld    [MAX_TAPS];

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic signed [fird_pkg::SAMPLE_W-1:0] w_sin;
        logic signed [ACC_W-1:0]              w_pin;
        logic                                 w_vin;

        if (k == 0) begin : g_head
            assign w_sin = w_sample;
            assign w_pin = '0;
            assign w_vin = r_go2;
        end else begin : g_body
            assign w_sin = w_hist[k-1];
            assign w_pin = w_psum[k-1];
            assign w_vin = w_vld[k-1];
        end

        // taps_in_use of zero still keeps the first tap
        assign w_ctrl[k].shift   = w_accept && w_is_sample;
        assign w_ctrl[k].coef_we = w_accept && w_is_coef && (32'(w_coef_idx) == k);
        assign w_ctrl[k].tap_en  = (k == 0) || (32'(r_taps) > k);

        fird_tap_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[k]),
            .i_sample   (w_sin),
            .i_coef     (w_coef_val),
            .i_psum     (w_pin),
            .i_psum_vld (w_vin),
            .o_sample   (w_hist[k]),
            .o_psum     (w_psum[k]),
            .o_psum_vld (w_vld[k])
        );
    end

    assign w_last_vld = w_vld[MAX_TAPS-1];

    // round half up, floor shift, saturate to the output width
    logic signed [ACC_W-1:0] w_rnd, w_shr;
    logic w_pos_ovf, w_neg_ovf;
    logic signed [fird_pkg::OUT_W-1:0] w_sat;

    assign w_rnd = w_psum[MAX_TAPS-1] + ACC_W'(1 << (fird_pkg::FRAC_BITS - 1));
    assign w_shr = w_rnd >>> fird_pkg::FRAC_BITS;
    assign w_pos_ovf = !w_shr[ACC_W-1] && (|w_shr[ACC_W-2:fird_pkg::OUT_W-1]);
    assign w_neg_ovf = w_shr[ACC_W-1] && !(&w_shr[ACC_W-2:fird_pkg::OUT_W-1]);

    always_comb begin
        if (w_pos_ovf) begin
            w_sat = {1'b0, {(fird_pkg::OUT_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            w_sat = {1'b1, {(fird_pkg::OUT_W-1){1'b0}}};
        end else begin
            w_sat = w_shr[fird_pkg::OUT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_last_vld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_vld) begin
            r_out_data <= w_sat;
            r_out_last <= r_last_pend;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // a finished sum never lands on a result that is still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_vld |-> (!r_out_vld || i_m_tready))
        else $error("result overwritten before transaction");

    // no item is taken while a sum runs down the cells
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_s_tready)
        else $error("input taken while busy");

    // start token only travels with a sum in flight
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_go1 || r_go2) |-> r_busy)
        else $error("start token without busy");

    // a result appears only after the last cell finishes
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_last_vld))
        else $error("result without finished sum");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_TAPS = fird_pkg::MAX_TAPS_DEF;
    // unmapped register index, writes to it must be dropped
    localparam logic [fird_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // receiver hold-off length, long enough for the core to back up
    localparam int HOLD_CYCLES = 400;

    // one filter output as seen on the result stream
    typedef struct {
        logic signed [fird_pkg::OUT_W-1:0] filtered;
        logic                              last_in_chunk;
    } t_fir_output;

    // tracks the filter state and the outputs still owed by the core
    class t_decimator_scoreboard;
        logic signed [fird_pkg::SAMPLE_W-1:0] history [MAX_TAPS];
        logic signed [fird_pkg::COEF_W-1:0]   coefs [MAX_TAPS];
        logic [fird_pkg::PHASE_W-1:0]         phase;
        logic [fird_pkg::CPOS_W-1:0]          chunk_pos;
        logic [fird_pkg::TAPS_W-1:0]          taps_reg;
        logic [fird_pkg::DEC_W-1:0]           dec_reg;
        logic [fird_pkg::CLEN_W-1:0]          clen_reg;
        t_fir_output                          pending_outputs [$];
        int                                   errors;

        function new();
            foreach (history[j]) history[j] = '0;
            foreach (coefs[j]) coefs[j] = '0;
            phase     = '0;
            chunk_pos = '0;
            taps_reg  = fird_pkg::TAPS_RST;
            dec_reg   = fird_pkg::DEC_RST;
            clen_reg  = fird_pkg::CLEN_RST;
            errors    = 0;
        endfunction

        function void set_reg(logic [fird_pkg::CFG_IDX_W-1:0] idx,
                              logic [fird_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fird_pkg::REG_TAPS: taps_reg = data[fird_pkg::TAPS_W-1:0];
                fird_pkg::REG_DEC:  dec_reg  = data[fird_pkg::DEC_W-1:0];
                fird_pkg::REG_CLEN: clen_reg = data[fird_pkg::CLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything above the ceiling acts as the ceiling
        function int unsigned clip(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void take_item(logic kind, logic [fird_pkg::SAMPLE_W-1:0] sample,
                                logic [fird_pkg::COEF_IDX_W-1:0] idx,
                                logic [fird_pkg::COEF_W-1:0] value);
            longint      acc;
            longint      rounded;
            int unsigned taps;
            int unsigned dec;
            int unsigned clen;
            t_fir_output result;
            if (kind == fird_pkg::KIND_COEF) begin
                // tap load only, history and counters stay put
                if (idx < MAX_TAPS) coefs[idx] = value;
                return;
            end
            for (int j = MAX_TAPS - 1; j > 0; j--) history[j] = history[j-1];
            history[0] = sample;
            dec = clip(dec_reg, fird_pkg::DEC_MAX);
            if (phase == 0) begin
                taps = clip(taps_reg, MAX_TAPS);
                clen = clip(clen_reg, fird_pkg::CLEN_MAX);
                acc = 0;
                for (int j = 0; j < taps; j++)
                    acc += longint'(coefs[j]) * longint'(history[j]);
                // round half up, floor shift, then saturate to 16 bits
                rounded = (acc + (longint'(1) << (fird_pkg::FRAC_BITS - 1)))
                          >>> fird_pkg::FRAC_BITS;
                if (rounded > 32767) rounded = 32767;
                else if (rounded < -32768) rounded = -32768;
                result.filtered = rounded[fird_pkg::OUT_W-1:0];
                if (chunk_pos + 1 >= clen) begin
                    result.last_in_chunk = 1'b1;
                    chunk_pos = '0;
                end else begin
                    result.last_in_chunk = 1'b0;
                    chunk_pos = chunk_pos + 1'b1;
                end
                pending_outputs.push_back(result);
            end
            if (phase + 1 >= dec) phase = '0;
            else phase = phase + 1'b1;
        endfunction

        function void check_output(logic [fird_pkg::OUT_W-1:0] filtered, logic last);
            t_fir_output want;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d last %0b",
                         $time, $signed(filtered), last);
                return;
            end
            want = pending_outputs.pop_front();
            if (filtered !== want.filtered) begin
                errors++;
                $display("%0t: filtered mismatch, expected %0d, actual %0d",
                         $time, want.filtered, $signed(filtered));
            end
            if (last !== want.last_in_chunk) begin
                errors++;
                $display("%0t: last_in_chunk mismatch, expected %0b, actual %0b",
                         $time, want.last_in_chunk, last);
            end
        endfunction
    endclass

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    // input stream
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [39:0]                     s_tdata  = '0;  // sample, coef_index, coef_value
    logic                            s_tuser  = 1'b0; // kind
    // result stream
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fird_pkg::OUT_W-1:0]      m_tdata;         // filtered[15:0]
    logic                            m_tlast;
    // configuration port
    logic                            cfg_we    = 1'b0;
    logic [fird_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fird_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // no idling on either side while set, apart from a requested hold-off
    bit steady   = 1'b0;
    // asks the result sink for one long hold-off
    bit hold_req = 1'b0;

    t_decimator_scoreboard sb = new();

    fir_decimator_core #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // offer one transaction, maybe after a random gap, and hold it until taken
    task automatic send_item(logic kind, logic [fird_pkg::SAMPLE_W-1:0] sample,
                             logic [fird_pkg::COEF_IDX_W-1:0] idx,
                             logic [fird_pkg::COEF_W-1:0] value);
        int gap;
        if (!steady && $urandom_range(99) < 29) begin
            // mostly short gaps, now and then one longer than a whole sum
            gap = $urandom_range(1, ($urandom_range(9) == 0) ? 80 : 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, idx, sample};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
        sb.take_item(kind, sample, idx, value);
    endtask

    // stop offering, let every owed output drain, then cover the core's latency
    // since samples off phase and tap loads leave nothing to wait on
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge i_clk);
        repeat (MAX_TAPS + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [fird_pkg::CFG_IDX_W-1:0] idx,
                             logic [fird_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mix of full range, small values and the corners
    function automatic logic [fird_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return fird_pkg::SAMPLE_W'($urandom);
            5, 6, 7:       return fird_pkg::SAMPLE_W'($urandom_range(1024) - 512);
            8:             return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default:       return $urandom_range(1) ? 16'h0000 : 16'hffff;
        endcase
    endfunction

    // small coefficients keep most sums out of saturation
    function automatic logic [fird_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(9))
            0, 1, 2: return fird_pkg::COEF_W'($urandom);
            9:       return $urandom_range(1) ? 18'h1ffff : 18'h20000;
            default: return fird_pkg::COEF_W'($urandom_range(8192) - 4096);
        endcase
    endfunction

    // register picks, including zero and values past the ceiling;
    // data bits above a 7-bit register are random and must be ignored
    function automatic logic [fird_pkg::CFG_DATA_W-1:0] pick_taps();
        int v;
        case ($urandom_range(5))
            0:       v = 0;
            1:       v = $urandom_range(65, 127);
            2:       v = MAX_TAPS;
            3:       v = 1;
            default: v = $urandom_range(2, 16);
        endcase
        return {6'($urandom), 7'(v)};
    endfunction

    function automatic logic [fird_pkg::CFG_DATA_W-1:0] pick_dec();
        int v;
        case ($urandom_range(7))
            0:       v = 0;
            1:       v = $urandom_range(65, 127);
            2:       v = 64;
            3:       v = $urandom_range(5, 12);
            default: v = $urandom_range(1, 4);
        endcase
        return {6'($urandom), 7'(v)};
    endfunction

    function automatic logic [fird_pkg::CFG_DATA_W-1:0] pick_clen();
        case ($urandom_range(6))
            0:       return 13'd0;
            1:       return 13'($urandom_range(4097, 8191));
            2:       return 13'd4096;
            3:       return 13'd1;
            default: return 13'($urandom_range(2, 12));
        endcase
    endfunction

    // result sink: checks each accepted transaction and drives tready,
    // counting out the long hold-off itself when asked for one
    initial begin : result_sink
        int hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 64 taps, every sample gives an output
        send_item(fird_pkg::KIND_COEF, 16'h1234, 6'd0, 18'h1ffff);
        send_item(fird_pkg::KIND_COEF, 16'hedcb, 6'd1, 18'h1ffff);
        send_item(fird_pkg::KIND_COEF, 16'h0000, 6'd63, 18'h20000);
        send_item(fird_pkg::KIND_SAMPLE, 16'h7fff, 6'h3f, 18'h3ffff);
        // two full-scale taps push the sum past the top
        send_item(fird_pkg::KIND_SAMPLE, 16'h7fff, 6'h00, 18'h00000);
        send_item(fird_pkg::KIND_SAMPLE, 16'h8000, 6'h2a, 18'h15555);
        // and past the bottom
        send_item(fird_pkg::KIND_SAMPLE, 16'h8000, 6'h15, 18'h2aaaa);
        send_item(fird_pkg::KIND_SAMPLE, 16'hffff, 6'h3f, 18'h3ffff);
        send_item(fird_pkg::KIND_SAMPLE, 16'h0001, 6'h00, 18'h00000);

        // zero in every register acts as one: one tap, every output ends a chunk
        wait_idle();
        write_reg(fird_pkg::REG_TAPS, 13'd0);
        write_reg(fird_pkg::REG_DEC, 13'd0);
        write_reg(fird_pkg::REG_CLEN, 13'd0);
        repeat (3)
            send_item(fird_pkg::KIND_SAMPLE, rand_sample(), 6'($urandom), 18'($urandom));

        // values past the ceilings act as the ceilings, and a write to the spare index is dropped
        wait_idle();
        write_reg(fird_pkg::REG_TAPS, 13'd127);
        write_reg(fird_pkg::REG_DEC, 13'd127);
        write_reg(fird_pkg::REG_CLEN, 13'd8191);
        write_reg(REG_SPARE, 13'h1fff);
        repeat (5)
            send_item(fird_pkg::KIND_SAMPLE, rand_sample(), 6'($urandom), 18'($urandom));

        // shrink decimation and chunk below the running counters
        wait_idle();
        write_reg(fird_pkg::REG_DEC, 13'd3);
        write_reg(fird_pkg::REG_CLEN, 13'd1);
        write_reg(fird_pkg::REG_TAPS, 13'd2);
        repeat (3)
            send_item(fird_pkg::KIND_SAMPLE, rand_sample(), 6'($urandom), 18'($urandom));

        // random phases, each under fresh settings
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            steady = (ph == 2 || ph == 5);
            write_reg(fird_pkg::REG_TAPS, pick_taps());
            // the hold-off phase runs at full rate so the core backs up
            write_reg(fird_pkg::REG_DEC, (ph == 5) ? 13'd1 : pick_dec());
            write_reg(fird_pkg::REG_CLEN, pick_clen());
            if ($urandom_range(3) == 0) write_reg(REG_SPARE, 13'($urandom));
            if (ph == 5) hold_req = 1'b1;
            repeat (62) begin
                if ($urandom_range(99) < 15)
                    send_item(fird_pkg::KIND_COEF, 16'($urandom), 6'($urandom),
                              rand_coef());
                else
                    send_item(fird_pkg::KIND_SAMPLE, rand_sample(), 6'($urandom),
                              18'($urandom));
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
            $display("tb_top passed");
        end else begin
            if (sb.pending_outputs.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, sb.pending_outputs.size());
            $display("tb_top failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fird_pkg.sv
hw/rtl/fird_tap_cell.sv
hw/rtl/fir_decimator_core.sv
bench/tb_top.sv
